/* hdl/cstd_pkg.sv */
// Package for the counting scale: field widths, operation codes, FSM states
// and the bundle passed from the tare/calibration store to the divider.
// No dependencies.
`default_nettype none

package cstd_pkg;

    localparam int SAMPLE_BITS   = 24;
    localparam int FRACTION_BITS = 8;
    localparam int NET_BITS      = SAMPLE_BITS + 1;            // signed net value
    localparam int MAG_BITS      = SAMPLE_BITS + 1;            // magnitude of net
    localparam int NUM_BITS      = MAG_BITS + FRACTION_BITS;   // scaled dividend
    localparam int OUT_BITS      = 33;
    localparam int CNT_BITS      = $clog2(NUM_BITS + 1);

    localparam logic [63:0] OUT_MAX_POS = (64'd1 << (OUT_BITS - 1)) - 64'd1;
    localparam logic [63:0] OUT_MAX_NEG = 64'd1 << (OUT_BITS - 1);

    localparam int IN_TDATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_BITS = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [1:0] {
        OP_MEASURE = 2'd0,
        OP_TARE    = 2'd1,
        OP_CAL     = 2'd2,
        OP_UNUSED  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } t_state;

    // Divider operands, prepared from the current sample and stored state
    typedef struct packed {
        logic [NUM_BITS-1:0] num;       // |net| shifted up by FRACTION_BITS
        logic [MAG_BITS-1:0] den;       // |unit weight|
        logic                neg;       // result sign
        logic                den_zero;  // unit weight is zero
    } t_div_args;

endpackage

`default_nettype wire

/* hdl/counting_scale_tare_divide.sv */
// Counting scale top level: control FSM, sign and saturation, output register.
// Depends on cstd_pkg, cstd_store and cstd_div.
//
//  channel | direction | tdata                  | tuser
//  --------+-----------+------------------------+---------------------
//  s       | in        | sample [23:0]          | op [1:0]
//  m       | out       | count_fixed [32:0]     | divide_error [0]
//
// A tare or calibrate transaction produces no result. A measure runs the
// serial divider over the 33 bits of scaled dividend, then the FSM sees the
// divider finish and loads the output register; zero unit weight skips the
// divider and goes straight to the done state.
// Reset (synchronous, active low) clears the offset, the unit weight and
// control state. A stalled output holds its transaction while the next
// input is accepted; the FSM waits in its done state only if a second result
// is ready before the first one is taken.
`default_nettype none

module counting_scale_tare_divide (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_s_tvalid,
    output logic                                  o_s_tready,
    input  wire  [cstd_pkg::IN_TDATA_BITS-1:0]    i_s_tdata,  // sample
    input  wire  [1:0]                            i_s_tuser,  // op
    output logic                                  o_m_tvalid,
    input  wire                                   i_m_tready,
    output logic [cstd_pkg::OUT_TDATA_BITS-1:0]   o_m_tdata,  // count_fixed, zero pad
    output logic [0:0]                            o_m_tuser   // divide_error
);
    import cstd_pkg::*;

    t_state              r_state;
    t_state              n_state;
    t_div_args           w_args;
    logic                w_accept;
    logic                w_div_start;
    logic                w_div_busy;
    logic [NUM_BITS-1:0] w_quot;
    logic                w_load;
    logic                w_out_free;

    // Held with the measure while the divider runs
    logic                r_neg;
    logic                r_zero;
    logic                r_out_valid;
    logic [OUT_BITS-1:0] r_out_count;
    logic                r_out_err;

    logic [63:0]         w_q64;
    logic [63:0]         w_qsat;
    logic [OUT_BITS-1:0] w_count;

    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_out_valid || i_m_tready;

    cstd_store u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_op     (i_s_tuser),
        .i_sample (i_s_tdata[SAMPLE_BITS-1:0]),
        .o_args   (w_args)
    );

    cstd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_args.num),
        .i_den   (w_args.den),
        .o_busy  (w_div_busy),
        .o_quot  (w_quot)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && t_op'(i_s_tuser) == OP_MEASURE) begin
                    n_state = w_args.den_zero ? ST_DONE : ST_DIV;
                end
            end
            ST_DIV: begin
                if (!w_div_busy) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // FSM outputs
    always_comb begin
        o_s_tready  = 1'b0;
        w_div_start = 1'b0;
        w_load      = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_tready  = 1'b1;
                w_div_start = w_accept && t_op'(i_s_tuser) == OP_MEASURE
                              && !w_args.den_zero;
            end
            ST_DONE: w_load = w_out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Capture sign and zero divisor with the measure
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_neg  <= w_args.neg;
            r_zero <= w_args.den_zero;
        end
    end

    // Clamp the magnitude to the signed output range, then apply the sign
    assign w_q64 = 64'(w_quot);
    always_comb begin
        if (r_neg) begin
            w_qsat = (w_q64 > OUT_MAX_NEG) ? OUT_MAX_NEG : w_q64;
        end else begin
            w_qsat = (w_q64 > OUT_MAX_POS) ? OUT_MAX_POS : w_q64;
        end
    end
    assign w_count = r_neg ? OUT_BITS'(64'd0 - w_qsat) : OUT_BITS'(w_qsat);

    // Output register: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_count <= r_zero ? '0 : w_count;
            r_out_err   <= r_zero;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_TDATA_BITS'(r_out_count);
    assign o_m_tuser  = r_out_err;

    // A measure with a usable unit weight starts the divider
    a_div_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && t_op'(i_s_tuser) == OP_MEASURE && !w_args.den_zero)
        |=> (r_state == ST_DIV && w_div_busy))
        else $error("divider not started on measure");

    // A zero unit weight bypasses the divider
    a_zero_bypass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && t_op'(i_s_tuser) == OP_MEASURE && w_args.den_zero)
        |=> (r_state == ST_DONE && !w_div_busy))
        else $error("zero unit weight did not bypass divider");

    // An error result carries a zero count
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> (o_m_tdata == '0))
        else $error("error result with nonzero count");

    // A new result appears only from the done state
    a_load_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> ($past(r_state) == ST_DONE))
        else $error("result loaded outside done state");

endmodule

`default_nettype wire

/* hdl/cstd_store.sv */
// Zero offset and unit weight registers, net value and divider operands.
// Depends on cstd_pkg.
`default_nettype none

module cstd_store (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_accept,
    input  wire  [1:0]                        i_op,
    input  wire  signed [cstd_pkg::SAMPLE_BITS-1:0] i_sample,
    output cstd_pkg::t_div_args               o_args
);
    import cstd_pkg::*;

    logic signed [SAMPLE_BITS-1:0] r_offset;
    logic signed [NET_BITS-1:0]    r_unit;
    logic signed [NET_BITS-1:0]    w_net;
    logic [MAG_BITS-1:0]           w_net_mag;
    logic [MAG_BITS-1:0]           w_unit_mag;

    // net always fits one bit more than the sample
    assign w_net = NET_BITS'(i_sample) - NET_BITS'(r_offset);

    assign w_net_mag  = w_net[NET_BITS-1]  ? MAG_BITS'(-w_net)  : MAG_BITS'(w_net);
    assign w_unit_mag = r_unit[NET_BITS-1] ? MAG_BITS'(-r_unit) : MAG_BITS'(r_unit);

    always_comb begin
        o_args.num      = {w_net_mag, {FRACTION_BITS{1'b0}}};
        o_args.den      = w_unit_mag;
        o_args.neg      = w_net[NET_BITS-1] ^ r_unit[NET_BITS-1];
        o_args.den_zero = (r_unit == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
            r_unit   <= '0;
        end else if (i_accept) begin
            case (t_op'(i_op))
                OP_TARE: r_offset <= i_sample;
                OP_CAL:  r_unit   <= w_net;
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

/* hdl/cstd_div.sv */
// Restoring divider, one quotient bit per cycle, unsigned magnitudes.
// Depends on cstd_pkg.
`default_nettype none

module cstd_div (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_start,
    input  wire  [cstd_pkg::NUM_BITS-1:0]   i_num,
    input  wire  [cstd_pkg::MAG_BITS-1:0]   i_den,
    output logic                            o_busy,
    output logic [cstd_pkg::NUM_BITS-1:0]   o_quot
);
    import cstd_pkg::*;

    logic [CNT_BITS-1:0] r_cnt;
    logic [NUM_BITS-1:0] r_num;     // dividend shifts out, quotient shifts in
    logic [MAG_BITS-1:0] r_rem;
    logic [MAG_BITS-1:0] r_den;
    logic [MAG_BITS:0]   w_trial;
    logic [MAG_BITS:0]   w_diff;
    logic                w_ge;

    assign w_trial = {r_rem, r_num[NUM_BITS-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_ge    = (w_trial >= {1'b0, r_den});

    assign o_busy = (r_cnt != '0);
    assign o_quot = r_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_BITS'(NUM_BITS);
        end else if (o_busy) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (o_busy) begin
            r_rem <= w_ge ? w_diff[MAG_BITS-1:0] : w_trial[MAG_BITS-1:0];
            r_num <= {r_num[NUM_BITS-2:0], w_ge};
        end
    end

endmodule

`default_nettype wire

/* sim/counting_scale_tare_divide_test.sv */
`timescale 1ns / 100ps
// Self-checking testbench for counting_scale_tare_divide: drives tare, calibrate and
// measure transactions, predicts every count in order and checks each result.
// Depends on cstd_pkg and the counting scale RTL.

module counting_scale_tare_divide_test;
    import cstd_pkg::*;

    localparam int     CLK_PERIOD     = 20;
    localparam int     RESET_CYCLES   = 9;
    localparam int     MAX_WAIT       = 13;     // longest gap or stall per transaction
    localparam int     SETTLE_CYCLES  = 40;     // a little over one divider pass
    localparam int     WATCHDOG_LIMIT = 5000;   // idle cycles before giving up
    localparam int     HOLD_CYCLES    = 300;    // long receiver hold-off
    localparam int     RANDOM_ITEMS   = 750;
    localparam longint SAMPLE_MAX     = 2 ** (SAMPLE_BITS - 1) - 1;
    localparam longint SAMPLE_MIN     = -(2 ** (SAMPLE_BITS - 1));

    typedef struct packed {
        logic [OUT_BITS-1:0] count_fixed;
        logic                divide_error;
    } t_count_result;

    logic                      i_clk      = 1'b0;
    logic                      i_rst_n    = 1'b0;
    logic                      i_s_tvalid = 1'b0;
    logic                      o_s_tready;
    logic [IN_TDATA_BITS-1:0]  i_s_tdata  = '0;          // sample
    logic [1:0]                i_s_tuser  = OP_MEASURE;  // op
    logic                      o_m_tvalid;
    logic                      i_m_tready = 1'b0;
    logic [OUT_TDATA_BITS-1:0] o_m_tdata;                // count_fixed, zero pad
    logic [0:0]                o_m_tuser;                // divide_error

    // Scale state as the block should hold it, reset values included
    logic signed [SAMPLE_BITS-1:0] tare_offset = '0;
    logic signed [NET_BITS-1:0]    unit_weight = '0;
    t_count_result                 pending_counts[$];
    t_count_result                 expected_count;

    // Idling controls shared between the tests and the two sides
    bit tx_gaps_on    = 1'b1;
    bit rx_stalls_on  = 1'b1;
    int rx_hold_left  = 0;
    int rx_stall_left = 0;
    int idle_cycles   = 0;

    int n_tares, n_cals, n_measures, n_zero_weight, n_ignored, n_checked, n_errors;

    counting_scale_tare_divide i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Net over unit weight, scaled by the fraction bits, truncated toward zero
    // and saturated to the output width; zero unit weight flags an error.
    function automatic t_count_result predict_count(longint net, longint unit);
        t_count_result res;
        longint        num;
        longint        den;
        longint        quo;
        bit            neg;
        res = '0;
        if (unit == 0) begin
            res.divide_error = 1'b1;
            return res;
        end
        num = (net < 0 ? -net : net) <<< FRACTION_BITS;
        den = unit < 0 ? -unit : unit;
        quo = num / den;
        neg = (net < 0) != (unit < 0);
        if (neg) begin
            if (quo > longint'(OUT_MAX_NEG))
                quo = longint'(OUT_MAX_NEG);
            quo = -quo;
        end else if (quo > longint'(OUT_MAX_POS)) begin
            quo = longint'(OUT_MAX_POS);
        end
        res.count_fixed = quo[OUT_BITS-1:0];
        return res;
    endfunction

    // Advance the scale state for one accepted transaction; queue the count
    // that a measure should produce.
    function automatic void weigh_transaction(t_op op, logic [SAMPLE_BITS-1:0] raw);
        longint smp;
        longint net;
        smp = longint'($signed(raw));
        net = smp - longint'(tare_offset);
        case (op)
            OP_TARE: begin
                tare_offset = raw;
                n_tares++;
            end
            OP_CAL: begin
                unit_weight = net[NET_BITS-1:0];
                n_cals++;
            end
            OP_MEASURE: begin
                if (unit_weight == 0)
                    n_zero_weight++;
                pending_counts.push_back(predict_count(net, longint'(unit_weight)));
                n_measures++;
            end
            default: begin
                n_ignored++;
            end
        endcase
    endfunction

    function automatic longint random_sample();
        logic [SAMPLE_BITS-1:0] raw;
        raw = SAMPLE_BITS'($urandom);
        return longint'($signed(raw));
    endfunction

    // Keep a derived sample if it fits the field, otherwise draw a fresh one
    function automatic longint fit_sample(longint v);
        if (v > SAMPLE_MAX || v < SAMPLE_MIN)
            return random_sample();
        return v;
    endfunction

    // Offer one transaction after a random gap and hold it until accepted.
    // Valid is only lowered when a gap follows, so back-to-back transactions
    // never see it dropped and raised at the same edge.
    task automatic send_sample(t_op op, longint smp);
        int gap;
        gap = tx_gaps_on ? $urandom_range(0, MAX_WAIT) : 0;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= smp[SAMPLE_BITS-1:0];
        i_s_tuser  <= op;
        do @(posedge i_clk); while (!o_s_tready);
        weigh_transaction(op, smp[SAMPLE_BITS-1:0]);
    endtask

    // Receiver: check each result against the oldest expectation, then stall
    // for a random number of cycles. A pending hold-off takes priority.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                if (pending_counts.size() == 0) begin
                    $error("unexpected result: count_fixed %0d, divide_error %0b",
                           $signed(o_m_tdata[OUT_BITS-1:0]), o_m_tuser[0]);
                    n_errors++;
                end else begin
                    expected_count = pending_counts.pop_front();
                    if (o_m_tdata[OUT_BITS-1:0] !== expected_count.count_fixed) begin
                        $error("count_fixed: expected %0d, actual %0d",
                               $signed(expected_count.count_fixed),
                               $signed(o_m_tdata[OUT_BITS-1:0]));
                        n_errors++;
                    end
                    if (o_m_tuser[0] !== expected_count.divide_error) begin
                        $error("divide_error: expected %0b, actual %0b",
                               expected_count.divide_error, o_m_tuser[0]);
                        n_errors++;
                    end
                    n_checked++;
                end
                rx_stall_left = rx_stalls_on ? $urandom_range(0, MAX_WAIT) : 0;
            end
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                i_m_tready <= 1'b0;
            end else if (rx_stall_left > 0) begin
                rx_stall_left--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run if no transaction moves on either side for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout after %0d idle cycles", idle_cycles);
                $display("counting_scale_tare_divide_test: done, errors");
                $finish;
            end
        end
    end

    // Field extremes, the unused op, zero unit weight, the largest positive count,
    // a large negative count and truncation toward zero.
    task automatic test_directed_extremes();
        send_sample(OP_MEASURE, 0);                 // zero unit weight after reset
        send_sample(OP_MEASURE, SAMPLE_MIN);
        send_sample(OP_UNUSED, SAMPLE_MAX);         // ignored, no result
        send_sample(OP_TARE, SAMPLE_MAX);
        send_sample(OP_CAL, SAMPLE_MIN);            // most negative unit weight
        send_sample(OP_MEASURE, SAMPLE_MIN);
        send_sample(OP_MEASURE, SAMPLE_MAX);
        send_sample(OP_UNUSED, 0);                  // state must stay put
        send_sample(OP_MEASURE, 0);
        send_sample(OP_TARE, SAMPLE_MIN);
        send_sample(OP_CAL, SAMPLE_MIN + 1);        // unit weight of one
        send_sample(OP_MEASURE, SAMPLE_MAX);        // largest positive count
        send_sample(OP_MEASURE, SAMPLE_MIN);
        send_sample(OP_TARE, SAMPLE_MIN + 1);
        send_sample(OP_CAL, SAMPLE_MIN);            // unit weight of minus one
        send_sample(OP_MEASURE, SAMPLE_MAX);        // large negative count
        send_sample(OP_TARE, 0);
        send_sample(OP_CAL, 3);
        send_sample(OP_MEASURE, -1);                // truncates toward zero
        send_sample(OP_MEASURE, 1);
        send_sample(OP_CAL, 0);                     // calibrate at the tare
        send_sample(OP_MEASURE, 12345);
        send_sample(OP_CAL, -1);
        send_sample(OP_MEASURE, SAMPLE_MIN);
    endtask

    // Hold the receiver off for a long stretch while measures keep coming, so
    // the output and the divider fill and the input stalls.
    task automatic test_backpressure();
        tx_gaps_on   = 1'b0;
        send_sample(OP_TARE, random_sample());
        send_sample(OP_CAL, fit_sample(longint'(tare_offset) + 100));
        rx_hold_left = HOLD_CYCLES;
        repeat (8) send_sample(OP_MEASURE, random_sample());
        tx_gaps_on   = 1'b1;
    endtask

    // Mostly tare, calibrate and a run of measures with random content; the
    // rest is noise and broken sequences. Idling is switched per session.
    task automatic test_random_weighing();
        int     goal;
        int     runs;
        longint base;
        longint delta;
        longint span;
        longint k;
        longint jitter;
        goal = n_tares + n_cals + n_measures + RANDOM_ITEMS;
        while (n_tares + n_cals + n_measures < goal) begin
            tx_gaps_on   = ($urandom_range(0, 3) != 0);
            rx_stalls_on = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 9))
                0: begin
                    repeat (4) send_sample(t_op'($urandom_range(0, 3)), random_sample());
                end
                1: begin
                    // calibrate at the current tare, then measure on zero weight
                    send_sample(OP_CAL, longint'(tare_offset));
                    repeat (2) send_sample(OP_MEASURE, random_sample());
                end
                default: begin
                    if ($urandom_range(0, 3) == 0)
                        base = random_sample();
                    else
                        base = longint'($urandom_range(0, 200000)) - 100000;
                    case ($urandom_range(0, 2))
                        0:       delta = longint'($urandom_range(1, 15));
                        1:       delta = longint'($urandom_range(16, 40000));
                        default: delta = longint'($urandom_range(40001, 8000000));
                    endcase
                    span = delta;
                    if ($urandom_range(0, 1))
                        delta = -delta;
                    send_sample(OP_TARE, base);
                    send_sample(OP_CAL, fit_sample(base + delta));
                    runs = $urandom_range(1, 12);
                    repeat (runs) begin
                        k      = longint'($urandom_range(0, 300)) - 20;
                        jitter = longint'($urandom_range(0, 32'(span))) - span / 2;
                        send_sample(OP_MEASURE, fit_sample(base + k * delta + jitter));
                    end
                end
            endcase
        end
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_extremes();
        test_backpressure();
        test_random_weighing();

        i_s_tvalid <= 1'b0;
        while (pending_counts.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d tares, %0d calibrations, %0d measures (%0d on zero weight)",
                 n_tares, n_cals, n_measures, n_zero_weight);
        $display("%0d unused-op transactions ignored, %0d results checked, %0d mismatches",
                 n_ignored, n_checked, n_errors);
        if (n_errors == 0)
            $display("counting_scale_tare_divide_test: done, clean");
        else
            $display("counting_scale_tare_divide_test: done, errors");
        $finish;
    end

endmodule
